// ----- src/bqlp_pkg.sv -----
`default_nettype none

package bqlp_pkg;

	// default sizes
	localparam int CHANNELS_DEF = 9;
	localparam int SECTIONS_DEF = 3;

	// fixed field and datapath widths
	localparam int SAMPLE_BITS = 16;
	localparam int CHAN_W      = 4;
	localparam int STATE_W     = 32;
	localparam int STATE_FRAC  = 8;
	localparam int COEF_W      = 25;
	localparam int COEF_FRAC   = 22;
	localparam int PROD_W      = STATE_W + COEF_W;
	localparam int ACC_W       = PROD_W + 2;
	localparam int STEP_W      = 4;
	localparam int SEC_IDX_W   = 3;
	localparam int RND_W       = STATE_W + 1 - STATE_FRAC;

	// input and output words
	typedef struct packed {
		logic [CHAN_W-1:0]             channel;
		logic signed [SAMPLE_BITS-1:0] sample;
	} item_t;

	typedef struct packed {
		logic [CHAN_W-1:0]             channel_out;
		logic signed [SAMPLE_BITS-1:0] filtered;
		logic                          clipped;
	} result_t;

	// microcode fields
	typedef enum logic [1:0] {
		OPND_Z1 = 2'd0,
		OPND_Z2 = 2'd1,
		OPND_W  = 2'd2
	} opnd_t;

	typedef enum logic [2:0] {
		COEF_A1 = 3'd0,
		COEF_A2 = 3'd1,
		COEF_B0 = 3'd2,
		COEF_B1 = 3'd3,
		COEF_B2 = 3'd4
	} coef_sel_t;

	typedef enum logic [2:0] {
		ACC_HOLD   = 3'd0,
		ACC_LOAD_Y = 3'd1,
		ACC_LOAD_P = 3'd2,
		ACC_ADD_P  = 3'd3,
		ACC_SUB_P  = 3'd4
	} acc_op_t;

	typedef struct packed {
		opnd_t     opnd;
		coef_sel_t coef;
		acc_op_t   acc_op;
		logic      take_w;
		logic      take_y;
		logic      mem_rd;
		logic      mem_wr;
		logic      last;
	} ctrl_t;

	// program addresses, one section per pass
	localparam logic [STEP_W-1:0] UC_READ = 4'd0;
	localparam logic [STEP_W-1:0] UC_FB1  = 4'd1;
	localparam logic [STEP_W-1:0] UC_FB2  = 4'd2;
	localparam logic [STEP_W-1:0] UC_FB3  = 4'd3;
	localparam logic [STEP_W-1:0] UC_W    = 4'd4;
	localparam logic [STEP_W-1:0] UC_FF0  = 4'd5;
	localparam logic [STEP_W-1:0] UC_FF1  = 4'd6;
	localparam logic [STEP_W-1:0] UC_FF2  = 4'd7;
	localparam logic [STEP_W-1:0] UC_FF3  = 4'd8;
	localparam logic [STEP_W-1:0] UC_Y    = 4'd9;
	localparam int STEPS_PER_SECTION = 10;

	// coefficient row of one section, q2.22
	typedef struct packed {
		logic signed [COEF_W-1:0] b0;
		logic signed [COEF_W-1:0] b1;
		logic signed [COEF_W-1:0] b2;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
	} coef_row_t;

	function automatic coef_row_t coef_row(input logic [SEC_IDX_W-1:0] sec);
		coef_row_t r;
		case (sec)
			3'd0: r = '{b0: 25'sd5453, b1: 25'sd5453, b2: 25'sd0,
				a1: -25'sd2136998, a2: 25'sd0};
			3'd1: r = '{b0: 25'sd4194304, b1: 25'sd8395319, b2: 25'sd4201015,
				a1: -25'sd4599474, a2: 25'sd1490656};
			3'd2: r = '{b0: 25'sd4194304, b1: 25'sd8386091, b2: 25'sd4191787,
				a1: -25'sd5743260, a2: 25'sd2904975};
			// unity pass-through
			default: r = '{b0: 25'sd4194304, b1: 25'sd0, b2: 25'sd0,
				a1: 25'sd0, a2: 25'sd0};
		endcase
		return r;
	endfunction

	// control store
	function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
		ctrl_t c;
		c = '{opnd: OPND_Z1, coef: COEF_A1, acc_op: ACC_HOLD, take_w: 1'b0,
			take_y: 1'b0, mem_rd: 1'b0, mem_wr: 1'b0, last: 1'b0};
		case (step)
			UC_READ: c.mem_rd = 1'b1;
			UC_FB1: begin
				c.acc_op = ACC_LOAD_Y;
				c.opnd   = OPND_Z1;
				c.coef   = COEF_A1;
			end
			UC_FB2: begin
				c.acc_op = ACC_SUB_P;
				c.opnd   = OPND_Z2;
				c.coef   = COEF_A2;
			end
			UC_FB3: c.acc_op = ACC_SUB_P;
			UC_W: c.take_w = 1'b1;
			UC_FF0: begin
				c.opnd   = OPND_W;
				c.coef   = COEF_B0;
				c.mem_wr = 1'b1;
			end
			UC_FF1: begin
				c.acc_op = ACC_LOAD_P;
				c.opnd   = OPND_Z1;
				c.coef   = COEF_B1;
			end
			UC_FF2: begin
				c.acc_op = ACC_ADD_P;
				c.opnd   = OPND_Z2;
				c.coef   = COEF_B2;
			end
			UC_FF3: c.acc_op = ACC_ADD_P;
			UC_Y: begin
				c.take_y = 1'b1;
				c.last   = 1'b1;
			end
			default: c.last = 1'b1;
		endcase
		return c;
	endfunction

	// round off the coefficient fraction and saturate to a delay word
	function automatic logic signed [STATE_W-1:0] round_sat(
		input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0]           t;
		logic [ACC_W-COEF_FRAC-1:0]        q;
		logic [ACC_W-COEF_FRAC-STATE_W:0]  hi;
		logic signed [STATE_W-1:0]         r;
		t  = acc + ACC_W'(1 << (COEF_FRAC - 1));
		q  = t[ACC_W-1:COEF_FRAC];
		hi = q[ACC_W-COEF_FRAC-1:STATE_W-1];
		if ((&hi) || !(|hi))
			r = q[STATE_W-1:0];
		else if (q[ACC_W-COEF_FRAC-1])
			r = {1'b1, {(STATE_W-1){1'b0}}};
		else
			r = {1'b0, {(STATE_W-1){1'b1}}};
		return r;
	endfunction

	// round a delay word to an integer sample, clip flag on top
	function automatic logic [SAMPLE_BITS:0] round_out(
		input logic signed [STATE_W-1:0] y);
		logic signed [STATE_W:0]           t;
		logic [RND_W-1:0]                  q;
		logic [RND_W-SAMPLE_BITS:0]        hi;
		logic [SAMPLE_BITS:0]              r;
		t  = (STATE_W+1)'(y) + (STATE_W+1)'(1 << (STATE_FRAC - 1));
		q  = t[STATE_W:STATE_FRAC];
		hi = q[RND_W-1:SAMPLE_BITS-1];
		if ((&hi) || !(|hi))
			r = {1'b0, q[SAMPLE_BITS-1:0]};
		else if (q[RND_W-1])
			r = {1'b1, 1'b1, {(SAMPLE_BITS-1){1'b0}}};
		else
			r = {1'b1, 1'b0, {(SAMPLE_BITS-1){1'b1}}};
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- src/biquad_cascade_lowpass.sv -----
// each accepted word runs the ten-step section program once per section, and ST_FIN
//   then loads its result word; the program runs on one shared multiplier and
//   one delay-memory port, and no new word is accepted before that load
// an out-of-range channel skips the section program and goes straight to ST_FIN
// reset: async, active low; a clearing pass zeroes every row of the delay memory
//   before the first word is accepted
`default_nettype none

module biquad_cascade_lowpass #(
	parameter int CHANNELS = bqlp_pkg::CHANNELS_DEF,
	parameter int SECTIONS = bqlp_pkg::SECTIONS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire bqlp_pkg::item_t   item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output bqlp_pkg::result_t      result
);

	localparam int ROWS  = CHANNELS * SECTIONS;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
	localparam int SW    = bqlp_pkg::STATE_W;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_RUN   = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

	state_t                                state_q;
	logic [bqlp_pkg::STEP_W-1:0]           upc_q;
	logic [SEC_W-1:0]                      sec_q;
	logic [ROW_W-1:0]                      row_q;
	logic [ROW_W-1:0]                      clr_q;
	logic                                  bad_q;
	logic [bqlp_pkg::CHAN_W-1:0]           chan_q;
	logic signed [SW-1:0]                  y_q;
	logic signed [SW-1:0]                  w_q;
	logic signed [bqlp_pkg::ACC_W-1:0]     acc_q;
	logic signed [bqlp_pkg::PROD_W-1:0]    prod_q;
	logic [2*SW-1:0]                       rd_q;
	logic                                  result_valid_q;
	bqlp_pkg::result_t                     result_q;

	// delay memory, one row {z2, z1} per channel and section
	logic [2*SW-1:0] mem [ROWS];

	bqlp_pkg::ctrl_t                       uc;
	bqlp_pkg::coef_row_t                   crow;
	logic signed [SW-1:0]                  mul_a;
	logic signed [bqlp_pkg::COEF_W-1:0]    mul_c;
	logic                                  in_run;
	logic                                  accept;
	logic                                  chan_ok;
	logic                                  load_out;
	logic                                  mem_we;
	logic                                  mem_re;
	logic [ROW_W-1:0]                      mem_wa;
	logic [2*SW-1:0]                       mem_wd;
	logic [bqlp_pkg::SAMPLE_BITS:0]        rnd;

	// control word fetch and coefficients of the current section
	assign uc   = bqlp_pkg::ucode(upc_q);
	assign crow = bqlp_pkg::coef_row(bqlp_pkg::SEC_IDX_W'(sec_q));

	assign in_run   = (state_q == ST_RUN);
	assign item_stall = (state_q != ST_IDLE);
	assign accept   = item_valid && !item_stall;
	assign chan_ok  = int'(item.channel) < CHANNELS;
	assign load_out = (state_q == ST_FIN) && (!result_valid_q || !result_stall);
	assign rnd      = bqlp_pkg::round_out(y_q);

	// multiplier operand selection
	always_comb begin
		case (uc.opnd)
			bqlp_pkg::OPND_Z1: mul_a = rd_q[SW-1:0];
			bqlp_pkg::OPND_Z2: mul_a = rd_q[2*SW-1:SW];
			bqlp_pkg::OPND_W:  mul_a = w_q;
			default:           mul_a = w_q;
		endcase
		case (uc.coef)
			bqlp_pkg::COEF_A1: mul_c = crow.a1;
			bqlp_pkg::COEF_A2: mul_c = crow.a2;
			bqlp_pkg::COEF_B0: mul_c = crow.b0;
			bqlp_pkg::COEF_B1: mul_c = crow.b1;
			bqlp_pkg::COEF_B2: mul_c = crow.b2;
			default:           mul_c = crow.b0;
		endcase
	end

	// memory port control: clearing pass or section update
	always_comb begin
		mem_re = in_run && uc.mem_rd;
		mem_we = (state_q == ST_CLEAR) || (in_run && uc.mem_wr);
		if (state_q == ST_CLEAR) begin
			mem_wa = clr_q;
			mem_wd = '0;
		end else begin
			mem_wa = row_q;
			mem_wd = {rd_q[SW-1:0], w_q};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re)
			rd_q <= mem[row_q];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			upc_q   <= '0;
			sec_q   <= '0;
			row_q   <= '0;
			clr_q   <= '0;
			bad_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ROW_W'(ROWS - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						bad_q   <= !chan_ok;
						row_q   <= ROW_W'(int'(item.channel) * SECTIONS);
						sec_q   <= '0;
						upc_q   <= '0;
						state_q <= chan_ok ? ST_RUN : ST_FIN;
					end
				end
				ST_RUN: begin
					if (uc.last) begin
						upc_q <= '0;
						if (sec_q == SEC_W'(SECTIONS - 1)) begin
							state_q <= ST_FIN;
						end else begin
							sec_q <= sec_q + 1'b1;
							row_q <= row_q + 1'b1;
						end
					end else begin
						upc_q <= upc_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (load_out)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: shared multiplier, accumulator, w and y registers
	always_ff @(posedge clk) begin
		prod_q <= bqlp_pkg::PROD_W'(mul_a) * bqlp_pkg::PROD_W'(mul_c);
		if (accept)
			chan_q <= item.channel;
		if (in_run) begin
			case (uc.acc_op)
				bqlp_pkg::ACC_LOAD_Y:
					acc_q <= bqlp_pkg::ACC_W'(y_q) <<< bqlp_pkg::COEF_FRAC;
				bqlp_pkg::ACC_LOAD_P: acc_q <= bqlp_pkg::ACC_W'(prod_q);
				bqlp_pkg::ACC_ADD_P:  acc_q <= acc_q + bqlp_pkg::ACC_W'(prod_q);
				bqlp_pkg::ACC_SUB_P:  acc_q <= acc_q - bqlp_pkg::ACC_W'(prod_q);
				default:              acc_q <= acc_q;
			endcase
			if (uc.take_w)
				w_q <= bqlp_pkg::round_sat(acc_q);
		end
		if (accept)
			y_q <= SW'(item.sample) <<< bqlp_pkg::STATE_FRAC;
		else if (in_run && uc.take_y)
			y_q <= bqlp_pkg::round_sat(acc_q);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			if (load_out)
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_q.channel_out <= chan_q;
			result_q.filtered    <= bad_q ? '0 : rnd[bqlp_pkg::SAMPLE_BITS-1:0];
			result_q.clipped     <= bad_q ? 1'b0 : rnd[bqlp_pkg::SAMPLE_BITS];
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// ----- src/bqlp_checker.sv -----
`default_nettype none

module bqlp_checker #(
	parameter int CHANNELS = bqlp_pkg::CHANNELS_DEF
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              item_valid,
	input wire logic              item_stall,
	input wire logic              result_valid,
	input wire logic              result_stall,
	input wire bqlp_pkg::result_t result
);

	localparam int SB = bqlp_pkg::SAMPLE_BITS;
	localparam logic [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
	localparam logic [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

	// a stalled result word stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result word dropped while stalled");

	// a stalled result word keeps its value
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result word changed while stalled");

	// one word in flight: an accepted word closes the input
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("input taken while a word is in flight");

	// clipped output sits at a rail
	a_clip: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.clipped |->
			(result.filtered == S_MAX) || (result.filtered == S_MIN))
		else $error("clip flag without saturated output");

	// unknown channel returns a zero word
	a_badch: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (int'(result.channel_out) >= CHANNELS) |->
			(result.filtered == '0) && !result.clipped)
		else $error("out-of-range channel gave nonzero output");

endmodule

bind biquad_cascade_lowpass bqlp_checker #(.CHANNELS(CHANNELS)) u_bqlp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

`default_nettype wire
